### rtl/rgblab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_pkg
// shared types, constants and the srgb linearization table
// ----------------------------------------------------------------------------
package rgblab_pkg;

  localparam int ChanBits = 8;
  localparam int OutField = 16;
  localparam int LinBits  = 25;   // q24 linear value, up to 1.0
  localparam int VBits    = 26;   // q24 ratio and companded value

  typedef logic [LinBits-1:0] lin_tab_t [256];
  typedef logic [15:0]        mat_row_t [3];
  typedef mat_row_t           mat_t [3];

  // rgb to xyz rows with the white point folded in, q16
  localparam mat_t Mat = '{
    '{16'd28435, 16'd24657, 16'd12446},
    '{16'd13933, 16'd46871, 16'd4732},
    '{16'd1162,  16'd7175,  16'd57210}
  };

  localparam logic [VBits-1:0] LabThresh = 26'd148579;
  localparam longint unsigned  LinSlope  = 64'd510329;
  localparam longint unsigned  LinOffset = 64'd2314099;

  // 255 * 2^24
  localparam longint unsigned  Den = 64'd4278190080;
  // exact reciprocal of 255 for dividends below 2^32, used with a 40 bit shift
  localparam logic [32:0]      Recip255 = 33'(((64'd1 << 40) + 64'd254) / 64'd255);

  function automatic logic [LinBits-1:0] lin_entry(input int unsigned c);
    longint unsigned t;
    longint unsigned t2;
    longint unsigned q;
    longint unsigned cand;
    longint unsigned p;
    if (c <= 10) begin
      return LinBits'((64'(c) * 64'd10 * (64'd1 << 24) + 64'd16473) / 64'd32946);
    end
    t  = ((64'(1000 * c + 14025) << 24) + 64'd134512) / 64'd269025;
    t2 = (t * t + (64'd1 << 23)) >> 24;
    q  = 64'd0;
    for (int b = 25; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      if (cand <= (64'd1 << 24)) begin
        p = cand;
        for (int i = 1; i < 5; i++) p = (p * cand) >> 24;
        if (p <= t2) q = cand;
      end
    end
    return LinBits'((t2 * q + (64'd1 << 23)) >> 24);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int c = 0; c < 256; c++) tab[c] = lin_entry(c);
    return tab;
  endfunction

  localparam lin_tab_t LinTab = build_lin_tab();

endpackage

### rtl/rgblab_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_mix
// gamma table lookup and xyz matrix, three stages
// ----------------------------------------------------------------------------
module rgblab_mix import rgblab_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [ChanBits-1:0] chan_i [3],
  output logic                valid_o,
  output logic [VBits-1:0]    v_o [3]
);

  logic [LinBits-1:0] lin_q [3];
  logic [40:0]        prod_q [3][3];
  logic [VBits-1:0]   v_q [3];
  logic [2:0]         vld_q;
  logic [42:0]        sum [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = 43'(prod_q[r][0]) + 43'(prod_q[r][1]) + 43'(prod_q[r][2]) + 43'd32768;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) lin_q[c] <= LinTab[chan_i[c]];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) prod_q[r][c] <= 41'(Mat[r][c]) * 41'(lin_q[c]);
        v_q[r] <= VBits'(sum[r] >> 16);
      end
    end
  end

  assign valid_o = vld_q[2];
  assign v_o     = v_q;

endmodule

### rtl/rgblab_compand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_compand
// cube root, one result bit per two stages, or the linear segment
// ----------------------------------------------------------------------------
module rgblab_compand import rgblab_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [VBits-1:0] v_i [3],
  output logic             valid_o,
  output logic [VBits-1:0] f_o [3]
);

  localparam int NB = VBits;

  // full stages hold the partial root, half stages the square of the candidate
  logic [VBits-1:0] v_q    [NB+1][3];
  logic [VBits-1:0] q_q    [NB+1][3];
  logic [VBits-1:0] lin_q  [NB+1][3];
  logic             sel_q  [NB+1][3];
  logic [NB:0]      vld_q;
  logic [VBits-1:0] vh_q   [NB][3];
  logic [VBits-1:0] qh_q   [NB][3];
  logic [VBits-1:0] cand_q [NB][3];
  logic [27:0]      sq_q   [NB][3];
  logic [VBits-1:0] linh_q [NB][3];
  logic             selh_q [NB][3];
  logic [NB-1:0]    vldh_q;

  logic [VBits-1:0] cand_d [NB][3];
  logic [29:0]      cube   [NB][3];
  logic [VBits-1:0] lin_d  [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lin_d[c] = VBits'(((46'(v_i[c]) * 46'(LinSlope) + 46'd32768) >> 16) + 46'(LinOffset));
    end
    for (int k = 0; k < NB; k++) begin
      for (int c = 0; c < 3; c++) begin
        cand_d[k][c] = q_q[k][c] | (VBits'(1) << (NB - 1 - k));
        cube[k][c]   = 30'((54'(sq_q[k][c]) * 54'(cand_q[k][c])) >> 24);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      vldh_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < NB; k++) begin
        vldh_q[k]  <= vld_q[k];
        vld_q[k+1] <= vldh_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        v_q[0][c]   <= v_i[c];
        q_q[0][c]   <= '0;
        lin_q[0][c] <= lin_d[c];
        sel_q[0][c] <= v_i[c] > LabThresh;
      end
      for (int k = 0; k < NB; k++) begin
        for (int c = 0; c < 3; c++) begin
          vh_q[k][c]   <= v_q[k][c];
          qh_q[k][c]   <= q_q[k][c];
          cand_q[k][c] <= cand_d[k][c];
          sq_q[k][c]   <= 28'((52'(cand_d[k][c]) * 52'(cand_d[k][c])) >> 24);
          linh_q[k][c] <= lin_q[k][c];
          selh_q[k][c] <= sel_q[k][c];

          v_q[k+1][c]   <= vh_q[k][c];
          q_q[k+1][c]   <= (cube[k][c] <= 30'(vh_q[k][c])) ? cand_q[k][c] : qh_q[k][c];
          lin_q[k+1][c] <= linh_q[k][c];
          sel_q[k+1][c] <= selh_q[k][c];
        end
      end
    end
  end

  assign valid_o = vld_q[NB];
  always_comb begin
    for (int c = 0; c < 3; c++) f_o[c] = sel_q[NB][c] ? q_q[NB][c] : lin_q[NB][c];
  end

endmodule

### rtl/rgblab_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgblab_scale
// forms l, a, b, scales by 1/255 with rounding and saturates, four stages
// ----------------------------------------------------------------------------
module rgblab_scale import rgblab_pkg::*; #(
  parameter int OutBits = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [VBits-1:0]    f_i [3],
  output logic                valid_o,
  output logic [OutField-1:0] res_o [3]
);

  logic signed [39:0] num_q [3];
  logic [31:0]        m_q [3];
  logic               sat_q [3];
  logic [64:0]        prod_q [3];
  logic               sat2_q [3];
  logic [OutField-1:0] res_q [3];
  logic [3:0]         vld_q;

  logic signed [39:0] fx, fy, fz;
  logic signed [39:0] num_d [3];
  logic [63:0]        n_u [3];
  logic [63:0]        m_d [3];
  logic [63:0]        q_d [3];

  localparam longint unsigned MaxOut = (64'd1 << OutBits) - 64'd1;

  always_comb begin
    fx = $signed(40'(f_i[0]));
    fy = $signed(40'(f_i[1]));
    fz = $signed(40'(f_i[2]));
    num_d[0] = fy * 40'sd116 - 40'sd268435456;
    num_d[1] = (fx - fy) * 40'sd1000 + $signed(40'(Den));
    num_d[2] = (fy - fz) * 40'sd400 + $signed(40'(Den));
    for (int c = 0; c < 3; c++) begin
      // half of the divisor is added before the shift, lightness divides by d,
      // the axes by 2d
      if (c == 0) begin
        n_u[c] = (64'(num_q[c]) << OutBits) + (Den >> 1);
        m_d[c] = n_u[c] >> 24;
      end else begin
        n_u[c] = (64'(num_q[c]) << OutBits) + Den;
        m_d[c] = n_u[c] >> 25;
      end
      if (num_q[c] <= 40'sd0) m_d[c] = '0;
      q_d[c] = 64'(prod_q[c] >> 40);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        num_q[c]  <= num_d[c];
        m_q[c]    <= 32'(m_d[c]);
        sat_q[c]  <= m_d[c] >= (64'd255 << OutBits);
        prod_q[c] <= 65'(m_q[c]) * 65'(Recip255);
        sat2_q[c] <= sat_q[c];
        res_q[c]  <= sat2_q[c] ? OutField'(MaxOut) : OutField'(q_d[c]);
      end
    end
  end

  assign valid_o = vld_q[3];
  assign res_o   = res_q;

endmodule

### rtl/rgb_to_cielab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_cielab
// srgb pixel to cielab (d65, 2 degree observer) in fixed point
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one pixel per item, m_axis one lab triple per item
//   each output is an unsigned fraction with OUT_BITS fraction bits,
//   lightness = l/255, the axes = a/255 + 0.5 and b/255 + 0.5, saturated
//   a result passes from input accept to output tvalid through the stages
//   for table and matrix, the cube root, and scaling and output
//   throughput is one item per clock unless the receiver stalls, set by the
//   fully pipelined cube root (two stages per root bit, 26 bits)
//   all stages advance together whenever the output register is empty or
//   being taken, so a receiver stall freezes the pipe and drops tready on
//   the input side; nothing is lost or repeated
//   reset clears every valid bit, data registers are left as they are
// ----------------------------------------------------------------------------
module rgb_to_cielab import rgblab_pkg::*; #(
  parameter int OUT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // lightness [15:0], green_red_axis [31:16],
                                      // blue_yellow_axis [47:32]
);

  logic                en;
  logic [ChanBits-1:0] chan [3];
  logic                mix_vld, cmp_vld;
  logic [VBits-1:0]    v [3];
  logic [VBits-1:0]    f [3];
  logic [OutField-1:0] res [3];

  // whole pipe moves when the output slot frees up
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign chan[0] = s_axis_tdata[7:0];
  assign chan[1] = s_axis_tdata[15:8];
  assign chan[2] = s_axis_tdata[23:16];

  rgblab_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .chan_i  (chan),
    .valid_o (mix_vld),
    .v_o     (v)
  );

  rgblab_compand u_compand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mix_vld),
    .v_i     (v),
    .valid_o (cmp_vld),
    .f_o     (f)
  );

  rgblab_scale #(
    .OutBits (OUT_BITS)
  ) u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cmp_vld),
    .f_i     (f),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  assign m_axis_tdata = {res[2], res[1], res[0]};

  // input side only stalls while a result waits
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  // saturation keeps results inside OUT_BITS
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((64'(m_axis_tdata[15:0]) >> OUT_BITS) == 64'd0 &&
                       (64'(m_axis_tdata[31:16]) >> OUT_BITS) == 64'd0 &&
                       (64'(m_axis_tdata[47:32]) >> OUT_BITS) == 64'd0))
    else $error("result exceeds OUT_BITS");

  // a stalled result is frozen by the shared enable
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule
